// ===== src/imq_pkg.sv =====
`timescale 1ns / 1ps

package imq_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_RAISE  = 3'd1,
        OP_LOWER  = 3'd2,
        OP_POP    = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PLACE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the accepted item, read the key store
        logic remove;  // unlink the current id from the sorted cells
        logic pop;     // drop the front cell
        logic place;   // insert the current id at its sorted position
        logic result;  // capture the result transfer
        logic ok;      // ok bit of the captured result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       in_range;
        logic       is_present;
        logic       key_gt_old;
        logic       key_lt_old;
        logic       not_empty;
    } dp_stat_t;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

endpackage

// ===== src/indexed_max_priority_queue.sv =====
`timescale 1ns / 1ps
// Indexed max-priority queue on a sorted shifting cell array.
// An input transfer is latched in IDLE and executed in EXEC; raise/lower key adds a
// PLACE state, and the registered result can be held back by m_tready. The controller
// runs one operation at a time (accept, execute, optional re-place step).
// Reset (aresetn low, synchronous): queue empty, no result pending.
module indexed_max_priority_queue #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: op[2:0], entry_id[10:3], new_key[42:11], zero fill to 48
    input  logic [imq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: ok[0], out_id[8:1], out_key[40:9], count[47:41]
    output logic [imq_pkg::M_TDATA_W-1:0] m_tdata
);
    import imq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: sequences accept, remove/pop, place and result capture.
    imq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: key store, presence bits, sorted cells, result register.
    imq_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// ===== src/imq_ctrl.sv =====
`timescale 1ns / 1ps

module imq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  imq_pkg::dp_stat_t stat,
    output imq_pkg::dp_cmd_t  cmd
);
    import imq_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   ok_c;
    logic   is_update;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        ok_c      = 1'b0;
        is_update = 1'b0;
        unique case (op_t'(stat.op))
            OP_INSERT: ok_c = stat.in_range && !stat.is_present;
            OP_RAISE: begin
                ok_c      = stat.in_range && stat.is_present && stat.key_gt_old;
                is_update = 1'b1;
            end
            OP_LOWER: begin
                ok_c      = stat.in_range && stat.is_present && stat.key_lt_old;
                is_update = 1'b1;
            end
            OP_POP:   ok_c = stat.not_empty;
            OP_QUERY: ok_c = stat.in_range && stat.is_present;
            default:  ok_c = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (is_update && ok_c) state_next = ST_PLACE;
                else if (out_free) state_next = ST_IDLE;
            end
            ST_PLACE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EXEC: begin
                if (is_update && ok_c) begin
                    cmd.remove = 1'b1;
                end else if (out_free) begin
                    cmd.result = 1'b1;
                    cmd.ok     = ok_c;
                    cmd.place  = ok_c && (op_t'(stat.op) == OP_INSERT);
                    cmd.pop    = ok_c && (op_t'(stat.op) == OP_POP);
                end
            end
            ST_PLACE: begin
                if (out_free) begin
                    cmd.place  = 1'b1;
                    cmd.result = 1'b1;
                    cmd.ok     = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_comb begin
        if (cmd.result) m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
        else m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== src/imq_dpath.sv =====
`timescale 1ns / 1ps

module imq_dpath #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [imq_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic [imq_pkg::M_TDATA_W-1:0]    m_tdata,
    input  imq_pkg::dp_cmd_t                 cmd,
    output imq_pkg::dp_stat_t                stat
);
    import imq_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LG = $clog2(MAX_ENTRIES);

    // latched item
    logic [2:0]                 op_reg;
    logic [7:0]                 id_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] old_key_reg;

    // key store
    logic signed [KEY_BITS-1:0] key_mem [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0]     present_reg;
    logic [CW-1:0]              count_reg, count_next;

    // sorted cells, front at index 0
    logic [IW-1:0]              cell_id_reg  [MAX_ENTRIES];
    logic signed [KEY_BITS-1:0] cell_key_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     cell_vld_reg;

    logic [MAX_ENTRIES-1:0]     match, after, shl, ins, first;
    logic [IW-1:0]              idx;
    logic                       in_range;

    logic                       out_ok_reg;
    logic [7:0]                 out_id_reg;
    logic [31:0]                out_key_reg;
    logic [6:0]                 out_count_reg;

    assign idx      = id_reg[IW-1:0];
    assign in_range = {1'b0, id_reg} < 9'(MAX_ENTRIES);

    assign stat.op         = op_reg;
    assign stat.in_range   = in_range;
    assign stat.is_present = in_range && present_reg[idx];
    assign stat.key_gt_old = key_reg > old_key_reg;
    assign stat.key_lt_old = key_reg < old_key_reg;
    assign stat.not_empty  = count_reg != '0;

    // shift mask: on remove the matching cell and every cell behind it (log-depth prefix OR), on pop all cells
    always_comb begin
        logic [MAX_ENTRIES-1:0] tmp;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = cell_vld_reg[i] && (cell_id_reg[i] == idx);
        end
        after = match;
        for (int l = 0; l < LG; l++) begin
            tmp = after;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (i >= (1 << l)) after[i] = tmp[i] | tmp[i - (1 << l)];
            end
        end
        shl = cmd.pop ? '1 : after;
    end

    // insert position: first cell that is empty or holds a smaller key
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            ins[i] = !cell_vld_reg[i] || (key_reg > cell_key_reg[i]);
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i == 0) first[i] = ins[i];
            else first[i] = ins[i] && !ins[i-1];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.place) count_next = count_reg + 1'b1;
        else if (cmd.remove || cmd.pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_tdata[2:0];
            id_reg      <= s_tdata[10:3];
            key_reg     <= KEY_BITS'($signed(s_tdata[42:11]));
            old_key_reg <= key_mem[s_tdata[3 +: IW]];
        end
        if (cmd.place) key_mem[idx] <= key_reg;
    end

    // cell payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (cmd.remove || cmd.pop) begin
                if (shl[i] && i < MAX_ENTRIES - 1) begin
                    cell_id_reg[i]  <= cell_id_reg[i+1];
                    cell_key_reg[i] <= cell_key_reg[i+1];
                end
            end else if (cmd.place) begin
                if (first[i]) begin
                    cell_id_reg[i]  <= idx;
                    cell_key_reg[i] <= key_reg;
                end else if (ins[i] && i > 0) begin
                    cell_id_reg[i]  <= cell_id_reg[i-1];
                    cell_key_reg[i] <= cell_key_reg[i-1];
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_vld_reg <= '0;
            present_reg  <= '0;
            count_reg    <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.pop) present_reg[cell_id_reg[0]] <= 1'b0;
            if (cmd.place) present_reg[idx] <= 1'b1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (cmd.remove || cmd.pop) begin
                    if (shl[i]) begin
                        if (i < MAX_ENTRIES - 1) cell_vld_reg[i] <= cell_vld_reg[i+1];
                        else cell_vld_reg[i] <= 1'b0;
                    end
                end else if (cmd.place) begin
                    if (ins[i]) begin
                        if (first[i]) cell_vld_reg[i] <= 1'b1;
                        else if (i > 0) cell_vld_reg[i] <= cell_vld_reg[i-1];
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            out_ok_reg    <= cmd.ok;
            out_count_reg <= 7'(count_next);
            if (cmd.ok && op_t'(op_reg) == OP_POP) begin
                out_id_reg  <= 8'(cell_id_reg[0]);
                out_key_reg <= 32'(cell_key_reg[0]);
            end else if (cmd.ok && op_t'(op_reg) == OP_QUERY) begin
                out_id_reg  <= '0;
                out_key_reg <= 32'(old_key_reg);
            end else begin
                out_id_reg  <= '0;
                out_key_reg <= '0;
            end
        end
    end

    assign m_tdata = {out_count_reg, out_key_reg, out_id_reg, out_ok_reg};

endmodule

// ===== tb/imq_checker.sv =====
`timescale 1ns / 1ps

module imq_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [imq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [imq_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending
);
    import imq_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic        ok;
        logic [7:0]  out_id;
        logic [31:0] out_key;
        logic [6:0]  count;
    } qresult_t;

    // shadow queue state
    logic               held [DEPTH];
    logic signed [31:0] keys [DEPTH];
    int                 sorted_ids [$];
    qresult_t           awaited [$];

    initial begin
        for (int i = 0; i < DEPTH; i++) held[i] = 1'b0;
    end

    // new entry goes behind every entry with greater or equal key
    function automatic void slot_in(int id);
        int p;
        p = 0;
        while (p < sorted_ids.size() && !(keys[id] > keys[sorted_ids[p]])) p++;
        sorted_ids.insert(p, id);
    endfunction

    function automatic void unlink(int id);
        for (int p = 0; p < sorted_ids.size(); p++)
            if (sorted_ids[p] == id) begin
                sorted_ids.delete(p);
                return;
            end
    endfunction

    function automatic qresult_t apply_op(logic [2:0] op, logic [7:0] id,
                                          logic signed [31:0] key);
        qresult_t r;
        logic     in_range;
        int       front;
        r = '0;
        in_range = id < DEPTH;
        case (op) inside
            OP_INSERT: if (in_range && !held[id]) begin
                keys[id] = key;
                held[id] = 1'b1;
                slot_in(id);
                r.ok = 1'b1;
            end
            OP_RAISE, OP_LOWER: if (in_range && held[id]) begin
                if (op == OP_RAISE ? key > keys[id] : key < keys[id]) begin
                    unlink(id);
                    keys[id] = key;
                    slot_in(id);
                    r.ok = 1'b1;
                end
            end
            OP_POP: if (sorted_ids.size() > 0) begin
                front = sorted_ids.pop_front();
                r.out_id = 8'(front);
                r.out_key = keys[front];
                held[front] = 1'b0;
                r.ok = 1'b1;
            end
            OP_QUERY: if (in_range && held[id]) begin
                r.out_key = keys[id];
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = 7'(sorted_ids.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        qresult_t want, got;
        if (aresetn && s_tvalid && s_tready)
            awaited.push_back(apply_op(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11]));
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[8:1], m_tdata[40:9], m_tdata[47:41]};
            if (awaited.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = awaited.pop_front();
                if (got.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, got.ok);
                    fail_count++;
                end
                if (got.out_id !== want.out_id) begin
                    $error("out_id: expected %0d, got %0d", want.out_id, got.out_id);
                    fail_count++;
                end
                if (got.out_key !== want.out_key) begin
                    $error("out_key: expected %0d, got %0d",
                           $signed(want.out_key), $signed(got.out_key));
                    fail_count++;
                end
                if (got.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, got.count);
                    fail_count++;
                end
            end
        end
        pending = awaited.size();
    end

endmodule

// ===== tb/indexed_max_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module indexed_max_priority_queue_tb;
    import imq_pkg::*;

    localparam int RANDOM_OPS = 750;
    localparam int STALL_LIMIT = 2000;   // idle cycles before giving up

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending;
    int                   quiet_cycles = 0;

    // which ids we believe are in the queue, for shaping valid sequences
    logic                 live [64];
    int                   live_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    indexed_max_priority_queue DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    imq_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // receiver: stretches of always-ready and stretches of random stalls
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge aclk);
            phase++;
            if ((phase / 64) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 99) < 60);
        end
    end

    // watchdog: count cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("indexed_max_priority_queue test failed");
            $finish;
        end
    end

    // one operation transfer; valid stays high across back-to-back sends
    task automatic send_op(logic [2:0] op, logic [7:0] id, logic [31:0] key);
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, key, id, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic logic [31:0] any_key();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 7);   // ties are common
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 8'($urandom_range(64, 255));
        return 8'($urandom_range(0, 63));
    endfunction

    initial begin
        int burst;
        logic [2:0] op;
        logic [7:0] id;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty cases, extremes, ties, bad ids and codes
        send_op(OP_POP, 8'd0, 32'd0);
        send_op(OP_QUERY, 8'd3, 32'd0);
        send_op(OP_RAISE, 8'd3, 32'd5);
        send_op(OP_INSERT, 8'd0, 32'h8000_0000);
        send_op(OP_POP, 8'd0, 32'd0);                  // lone entry
        send_op(OP_INSERT, 8'd63, 32'h7FFF_FFFF);
        send_op(OP_INSERT, 8'd1, 32'd10);
        send_op(OP_INSERT, 8'd2, 32'd10);              // tie, behind id 1
        send_op(OP_INSERT, 8'd2, 32'd99);              // already present
        send_op(OP_INSERT, 8'd64, 32'd1);              // out of range
        send_op(OP_INSERT, 8'd255, 32'd1);
        send_op(OP_RAISE, 8'd1, 32'd10);               // not strictly larger
        send_op(OP_LOWER, 8'd2, 32'd10);               // not strictly smaller
        send_op(OP_LOWER, 8'd63, 32'd10);              // ties behind 1 and 2
        send_op(OP_RAISE, 8'd2, 32'h7FFF_FFFF);
        send_op(OP_QUERY, 8'd2, 32'd0);
        send_op(OP_QUERY, 8'd200, 32'd0);
        send_op(3'd5, 8'd1, 32'd0);
        send_op(3'd7, 8'd1, 32'hFFFF_FFFF);
        repeat (4) send_op(OP_POP, 8'd0, 32'd0);
        gap(1);
        for (int i = 0; i < 64; i++) live[i] = 1'b0;

        // random: mostly well-formed ops on live ids, with bursts and gaps
        for (int n = 0; n < RANDOM_OPS; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < RANDOM_OPS; b++, n++) begin
                id = pick_id();
                case ($urandom_range(0, 99)) inside
                    [0:34]:  op = (live_count > 56) ? OP_POP : OP_INSERT;
                    [35:49]: op = OP_RAISE;
                    [50:64]: op = OP_LOWER;
                    [65:84]: op = OP_POP;
                    [85:96]: op = OP_QUERY;
                    default: op = 3'($urandom_range(5, 7));
                endcase
                if (op == OP_INSERT && id < 64 && live[id] && live_count < 64)
                    while (live[id[5:0]]) id = 8'($urandom_range(0, 63));
                else if ((op == OP_RAISE || op == OP_LOWER || op == OP_QUERY)
                         && live_count > 0 && id < 64 && $urandom_range(0, 3) != 0)
                    while (!live[id[5:0]]) id = 8'($urandom_range(0, 63));
                if (op == OP_INSERT && id < 64 && !live[id]) begin
                    live[id] = 1'b1;
                    live_count++;
                end
                // pops: resync our liveness guess loosely (only for shaping)
                if (op == OP_POP && live_count > 0 && pending == 0) begin
                    for (int k = 0; k < 64; k++) live[k] = 1'b0;
                    live_count = 0;
                end
                send_op(op, id, any_key());
            end
            if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 8));
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("indexed_max_priority_queue test passed");
        end else begin
            $display("indexed_max_priority_queue test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/imq_pkg.sv
src/imq_ctrl.sv
src/imq_dpath.sv
src/indexed_max_priority_queue.sv
tb/imq_checker.sv
tb/indexed_max_priority_queue_tb.sv
